/* hdl/gcode_line_parser_top_macros.svh */
// Assertion macros for the G-code line parser top level.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef GCODE_LINE_PARSER_TOP_MACROS_SVH
`define GCODE_LINE_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCL_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/gcl_pkg.sv */
// Shared types, byte codes and command codes for the G-code line parser.
// Used by gcl_parse, gcl_rec_fifo and gcode_line_parser_top; no dependencies.
package gcl_pkg;

	// Default configuration
	localparam int MAX_ARGS_DEF    = 16;
	localparam int FRAC_DIGITS_DEF = 3;

	// Record queue geometry
	localparam int REC_DEPTH = 4;
	localparam int PTR_W     = $clog2(REC_DEPTH);
	localparam int LVL_W     = $clog2(REC_DEPTH + 1);

	// Text bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h4D;

	// Command letters
	localparam logic LETTER_G = 1'b0;
	localparam logic LETTER_M = 1'b1;

	// Opcode numbers
	localparam logic [9:0] OP_0   = 10'd0;
	localparam logic [9:0] OP_1   = 10'd1;
	localparam logic [9:0] OP_3   = 10'd3;
	localparam logic [9:0] OP_5   = 10'd5;
	localparam logic [9:0] OP_28  = 10'd28;
	localparam logic [9:0] OP_90  = 10'd90;
	localparam logic [9:0] OP_91  = 10'd91;
	localparam logic [9:0] OP_92  = 10'd92;
	localparam logic [9:0] OP_MAX = 10'd1023;

	// Command codes
	localparam logic [3:0] CMD_G0  = 4'd0;
	localparam logic [3:0] CMD_G1  = 4'd1;
	localparam logic [3:0] CMD_G28 = 4'd2;
	localparam logic [3:0] CMD_G90 = 4'd3;
	localparam logic [3:0] CMD_G91 = 4'd4;
	localparam logic [3:0] CMD_G92 = 4'd5;
	localparam logic [3:0] CMD_M3  = 4'd6;
	localparam logic [3:0] CMD_M5  = 4'd7;
	localparam logic [3:0] CMD_M92 = 4'd8;

	// Record kinds
	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [3:0]         cmd;
		logic [7:0]         key;
		logic signed [31:0] value;
		logic [4:0]         count;
		logic               last;
	} gcl_rec_t;

	// Records produced by one byte, pushed into the queue together
	typedef struct packed {
		logic [1:0] cnt;
		gcl_rec_t   first;
		gcl_rec_t   second;
	} gcl_push_t;

	typedef struct packed {
		logic             room;
		logic [LVL_W-1:0] level;
	} gcl_fifo_stat_t;

	// Powers of ten for fixed-point scaling
	function automatic logic [31:0] pow10(input logic [3:0] n);
		logic [31:0] p;
		unique case (n)
			4'd0: p = 32'd1;
			4'd1: p = 32'd10;
			4'd2: p = 32'd100;
			4'd3: p = 32'd1000;
			4'd4: p = 32'd10000;
			4'd5: p = 32'd100000;
			4'd6: p = 32'd1000000;
			4'd7: p = 32'd10000000;
			4'd8: p = 32'd100000000;
			default: p = 32'd1000000000;
		endcase
		return p;
	endfunction

endpackage

/* hdl/gcl_parse.sv */
// Byte input register, parse state and per-byte step logic of the G-code parser.
// Depends on gcl_pkg; feeds up to two records per byte to gcl_rec_fifo.
module gcl_parse #(
	parameter int MAX_ARGS    = gcl_pkg::MAX_ARGS_DEF,
	parameter int FRAC_DIGITS = gcl_pkg::FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  logic [7:0]          char_byte,
	input  logic                room,
	output gcl_pkg::gcl_push_t  push
);
	import gcl_pkg::*;

	localparam logic [2:0] PH_LINE   = 3'd0;
	localparam logic [2:0] PH_OPCODE = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_WAIT   = 3'd3;
	localparam logic [2:0] PH_SIGN   = 3'd4;
	localparam logic [2:0] PH_NUM    = 3'd5;

	localparam logic [31:0] SCALE = pow10(4'(FRAC_DIGITS));
	localparam int PW = $clog2(SCALE + 1);
	localparam int FW = (SCALE > 1) ? $clog2(SCALE) : 1;
	localparam int MW = 33 + PW;
	localparam int DW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int AW = $clog2(MAX_ARGS + 1);

	localparam logic [MW-1:0] NEG_CAP = MW'(64'h8000_0000);
	localparam logic [MW-1:0] POS_CAP = MW'(64'h7FFF_FFFF);
	localparam logic [35:0]   INT_CAP = 36'h0_8000_0000;

	// Input register
	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       adv;

	// Parse state
	logic [2:0]    phase_q, phase_n;
	logic          letter_q, letter_n;
	logic [9:0]    opacc_q, opacc_n;
	logic [3:0]    cmd_q, cmd_n;
	logic [7:0]    key_q, key_n;
	logic          neg_q, neg_n;
	logic [31:0]   int_q, int_n;
	logic [FW-1:0] frac_q, frac_n;
	logic [DW-1:0] fd_q, fd_n;
	logic          point_q, point_n;
	logic [AW-1:0] args_q, args_n;

	// Step helpers
	logic          is_dig, is_term, is_end_byte;
	logic [3:0]    dig;
	logic [35:0]   int_mul;
	logic [31:0]   int_sat;
	logic [13:0]   op_mul;
	logic [9:0]    op_sat;
	logic [3:0]    fexp;
	logic [31:0]   frac_add;
	logic [AW-1:0] args_inc;
	logic [MW-1:0] mag;
	logic [31:0]   mag_c;
	logic [31:0]   value;
	logic          cmd_ok;
	logic [3:0]    cmd_look;
	logic          do_num, do_wait;
	logic          e0, e0_param, e1;
	logic [AW+4:0] args_ext;

	// Accept a byte when the register is empty or moves on this cycle
	assign adv        = valid_s1 && room;
	assign char_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			byte_s1 <= char_byte;
		end
	end

	// Byte classes and accumulators
	assign is_dig      = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign dig         = byte_s1[3:0];
	assign is_term     = (byte_s1 == CH_NL) || (byte_s1 == CH_NUL);
	assign is_end_byte = is_term || (byte_s1 == CH_SEMI);

	assign int_mul  = {4'b0, int_q} * 36'd10 + {32'b0, dig};
	assign int_sat  = (int_mul > INT_CAP) ? 32'h8000_0000 : int_mul[31:0];
	assign op_mul   = {4'b0, opacc_q} * 14'd10 + {10'b0, dig};
	assign op_sat   = (op_mul > {4'b0, OP_MAX}) ? OP_MAX : op_mul[9:0];
	assign fexp     = 4'(FRAC_DIGITS - 1 - int'(fd_q));
	assign frac_add = {28'b0, dig} * pow10(fexp);
	assign args_inc = args_q + AW'(1);

	// Scale to fixed point, then saturate and apply the sign
	assign mag = MW'(int_q) * MW'(SCALE) + MW'(frac_q);

	always_comb begin
		mag_c = 32'h0;
		if (neg_q) begin
			mag_c = (mag > NEG_CAP) ? 32'h8000_0000 : mag[31:0];
			value = ~mag_c + 32'd1;
		end else begin
			value = (mag > POS_CAP) ? 32'h7FFF_FFFF : mag[31:0];
		end
	end

	// Map letter and opcode to a command code
	always_comb begin
		cmd_ok   = 1'b1;
		cmd_look = CMD_G0;
		if (letter_q == LETTER_G) begin
			priority if (opacc_q == OP_0)  cmd_look = CMD_G0;
			else if (opacc_q == OP_1)  cmd_look = CMD_G1;
			else if (opacc_q == OP_28) cmd_look = CMD_G28;
			else if (opacc_q == OP_90) cmd_look = CMD_G90;
			else if (opacc_q == OP_91) cmd_look = CMD_G91;
			else if (opacc_q == OP_92) cmd_look = CMD_G92;
			else cmd_ok = 1'b0;
		end else begin
			priority if (opacc_q == OP_3)  cmd_look = CMD_M3;
			else if (opacc_q == OP_5)  cmd_look = CMD_M5;
			else if (opacc_q == OP_92) cmd_look = CMD_M92;
			else cmd_ok = 1'b0;
		end
	end

	// One parse step for the byte in the input register
	always_comb begin
		phase_n  = phase_q;
		letter_n = letter_q;
		opacc_n  = opacc_q;
		cmd_n    = cmd_q;
		key_n    = key_q;
		neg_n    = neg_q;
		int_n    = int_q;
		frac_n   = frac_q;
		fd_n     = fd_q;
		point_n  = point_q;
		args_n   = args_q;
		do_num   = 1'b0;
		do_wait  = 1'b0;
		e0       = 1'b0;
		e0_param = 1'b0;
		e1       = 1'b0;

		unique case (phase_q)
			PH_OPCODE: begin
				if (is_dig) begin
					opacc_n = op_sat;
				end else if (!cmd_ok) begin
					phase_n = is_term ? PH_LINE : PH_SKIP;
				end else begin
					cmd_n   = cmd_look;
					args_n  = '0;
					phase_n = PH_WAIT;
					do_wait = 1'b1;
				end
			end
			PH_SKIP: begin
				if (is_term) begin
					phase_n = PH_LINE;
				end
			end
			PH_WAIT: begin
				do_wait = 1'b1;
			end
			PH_SIGN: begin
				phase_n = PH_NUM;
				if (byte_s1 == CH_MINUS) begin
					neg_n = 1'b1;
				end else begin
					do_num = 1'b1;
				end
			end
			PH_NUM: begin
				do_num = 1'b1;
			end
			default: begin
				phase_n = PH_LINE;
				if (byte_s1 == CH_G || byte_s1 == CH_M) begin
					letter_n = (byte_s1 == CH_M) ? LETTER_M : LETTER_G;
					opacc_n  = '0;
					phase_n  = PH_OPCODE;
				end else if (byte_s1 != CH_SPACE && !is_term) begin
					phase_n = PH_SKIP;
				end
			end
		endcase

		// Number digits, decimal point, or close the parameter
		if (do_num) begin
			priority if (is_dig) begin
				if (!point_q) begin
					int_n = int_sat;
				end else if (fd_q < DW'(FRAC_DIGITS)) begin
					frac_n = frac_q + FW'(frac_add);
					fd_n   = fd_q + DW'(1);
				end
			end else if (byte_s1 == CH_DOT) begin
				if (point_q) begin
					e0      = 1'b1;
					phase_n = PH_SKIP;
				end else begin
					point_n = 1'b1;
				end
			end else begin
				args_n   = args_inc;
				e0       = 1'b1;
				e0_param = 1'b1;
				if (args_inc >= AW'(MAX_ARGS)) begin
					e1      = 1'b1;
					phase_n = is_term ? PH_LINE : PH_SKIP;
				end else begin
					phase_n = PH_WAIT;
					do_wait = 1'b1;
				end
			end
		end

		// Between parameters: end the command or start a new key
		if (do_wait) begin
			priority if (byte_s1 == CH_SPACE) begin
				phase_n = PH_WAIT;
			end else if (is_end_byte) begin
				if (e0) begin
					e1 = 1'b1;
				end else begin
					e0 = 1'b1;
				end
				phase_n = (byte_s1 == CH_SEMI) ? PH_SKIP : PH_LINE;
			end else begin
				key_n   = byte_s1;
				neg_n   = 1'b0;
				int_n   = '0;
				frac_n  = '0;
				fd_n    = '0;
				point_n = 1'b0;
				phase_n = PH_SIGN;
			end
		end
	end

	// Build the records for the queue
	assign args_ext = {5'b0, args_n};

	always_comb begin
		push.cnt          = adv ? ({1'b0, e0} + {1'b0, e1}) : 2'd0;
		push.first.kind   = e0_param ? KIND_PARAM : KIND_END;
		push.first.cmd    = cmd_n;
		push.first.key    = e0_param ? key_q : 8'h00;
		push.first.value  = e0_param ? value : 32'sd0;
		push.first.count  = args_ext[4:0];
		push.first.last   = !e1;
		push.second.kind  = KIND_END;
		push.second.cmd   = cmd_n;
		push.second.key   = 8'h00;
		push.second.value = 32'sd0;
		push.second.count = args_ext[4:0];
		push.second.last  = 1'b1;
	end

	// Advance parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE;
			letter_q <= LETTER_G;
			opacc_q  <= '0;
			cmd_q    <= CMD_G0;
			key_q    <= '0;
			neg_q    <= 1'b0;
			int_q    <= '0;
			frac_q   <= '0;
			fd_q     <= '0;
			point_q  <= 1'b0;
			args_q   <= '0;
		end else if (adv) begin
			phase_q  <= phase_n;
			letter_q <= letter_n;
			opacc_q  <= opacc_n;
			cmd_q    <= cmd_n;
			key_q    <= key_n;
			neg_q    <= neg_n;
			int_q    <= int_n;
			frac_q   <= frac_n;
			fd_q     <= fd_n;
			point_q  <= point_n;
			args_q   <= args_n;
		end
	end

endmodule

/* hdl/gcl_rec_fifo.sv */
// Four-entry record queue that takes up to two records per cycle, gives one unless stalled.
// Depends on gcl_pkg for the record types and queue geometry.
module gcl_rec_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gcl_pkg::gcl_push_t      push,
	output logic                    rec_valid,
	input  logic                    rec_stall,
	output gcl_pkg::gcl_rec_t       rec,
	output gcl_pkg::gcl_fifo_stat_t stat
);
	import gcl_pkg::*;

	gcl_rec_t         ent_q [REC_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_nx1;
	logic [LVL_W-1:0] lvl_q;
	logic             pop;

	assign wr_nx1    = wr_q + PTR_W'(1);
	assign rec_valid = (lvl_q != '0);
	assign rec       = ent_q[rd_q];
	assign pop       = rec_valid && !rec_stall;
	assign stat.room  = (lvl_q <= LVL_W'(REC_DEPTH - 2));
	assign stat.level = lvl_q;

	// Write the first record at the tail, the second just after it
	always_ff @(posedge clk) begin
		for (int i = 0; i < REC_DEPTH; i++) begin
			if (push.cnt != 2'd0 && PTR_W'(i) == wr_q) begin
				ent_q[i] <= push.first;
			end else if (push.cnt == 2'd2 && PTR_W'(i) == wr_nx1) begin
				ent_q[i] <= push.second;
			end
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.cnt);
			rd_q  <= rd_q + PTR_W'(pop);
			lvl_q <= lvl_q + LVL_W'(push.cnt) - LVL_W'(pop);
		end
	end

endmodule

/* hdl/gcode_line_parser_top.sv */
// Top level of the G-code line parser: parse stage plus record queue.
// Depends on gcl_pkg, gcl_parse, gcl_rec_fifo and the assertion macro header.
//
//  channel | direction | handshake              | payload
//  char    | in        | char_valid, char_stall | char_byte
//  rec     | out       | rec_valid, rec_stall   | record_kind, command_code, param_key,
//          |           |                        | param_value, arg_count, last
//
// One text byte is taken per cycle while char_stall is low; an accepted byte waits in
// the byte register until the queue has room, then its records are written to the queue.
// The parse step is combinational between the byte register and a four-entry record
// queue; a byte giving two records is offered as two records, one after the other.
// char_stall rises while a byte waits and the queue has fewer than two free entries.
// arst_n clears the parse state to line start and empties the queue.
module gcode_line_parser_top #(
	parameter int MAX_ARGS    = gcl_pkg::MAX_ARGS_DEF,
	parameter int FRAC_DIGITS = gcl_pkg::FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_byte,
	output logic               rec_valid,
	input  logic               rec_stall,
	output logic               record_kind,
	output logic [3:0]         command_code,
	output logic [7:0]         param_key,
	output logic signed [31:0] param_value,
	output logic [4:0]         arg_count,
	output logic               last
);
	import gcl_pkg::*;

	gcl_push_t      push;
	gcl_rec_t       rec;
	gcl_fifo_stat_t fifo_stat;

	// Parse one byte per cycle while not stalled
	gcl_parse #(
		.MAX_ARGS    (MAX_ARGS),
		.FRAC_DIGITS (FRAC_DIGITS)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_byte  (char_byte),
		.room       (fifo_stat.room),
		.push       (push)
	);

	// Hold records until taken
	gcl_rec_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec),
		.stat      (fifo_stat)
	);

	assign record_kind  = rec.kind;
	assign command_code = rec.cmd;
	assign param_key    = rec.key;
	assign param_value  = rec.value;
	assign arg_count    = rec.count;
	assign last         = rec.last;

	`include "gcode_line_parser_top_macros.svh"

	`GCL_ASSERT_HOLDS(a_level_bound, 1'b1, fifo_stat.level <= LVL_W'(REC_DEPTH), "queue level above depth")
	`GCL_ASSERT_HOLDS(a_push_room, push.cnt != 2'd0, fifo_stat.room, "records pushed without room")
	`GCL_ASSERT_HOLDS(a_stall_cause, char_stall, !fifo_stat.room, "input stalled while queue has room")
	`GCL_ASSERT_NEXT(a_push_shows, push.cnt != 2'd0, rec_valid, "pushed record not offered")

endmodule
